/* hw/rtl/aging_priority_task_selector_defines.svh */
// Assertion macros used by the checker of the task selector.
`ifndef AGING_PRIORITY_TASK_SELECTOR_DEFINES_SVH
`define AGING_PRIORITY_TASK_SELECTOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define APTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define APTS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/apts_pkg.sv */
`default_nettype none

package apts_pkg;

  localparam int PRIO_W   = 6;
  localparam int STAMP_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_ID_BITS   = 8;

  localparam logic signed [PRIO_W-1:0] FLOOR_RESET = -6'sd20;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/apts_ram.sv */
`default_nettype none

module apts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/aging_priority_task_selector.sv */
// Ready table of up to MAX_TASKS tasks with aging priorities. Pulse start while busy is low
// to issue one beat: op 0 enqueues task_ident at static priority priority_req, op 1 picks the
// ready task with the lowest dynamic priority (ties to the earliest enqueued) and ages all
// others toward aging_floor. The result is shown for exactly one cycle with done high and
// cannot be held off, so capture it then. A pick walks the whole slot memory one entry per
// cycle, so it keeps the block busy through the S_PICK walk and the S_TAIL step; an enqueue
// walks the valid bits to the lowest free slot and writes there, and an enqueue into a full
// table answers in the next cycle without going busy. A new beat may start in the cycle that
// done is high. Write aging_floor through the cfg channel only while busy is low.
`default_nettype none

module aging_priority_task_selector import apts_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic [ID_BITS-1:0]       task_ident,
  input  logic signed [PRIO_W-1:0] priority_req,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [ID_BITS-1:0]       picked_ident,
  output logic [COUNT_W-1:0]       ready_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic signed [PRIO_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int OCC_W  = $clog2(MAX_TASKS + 1);
  localparam int WORD_W = ID_BITS + PRIO_W + STAMP_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(MAX_TASKS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENQ  = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [1:0]               state;
  logic [IDX_W-1:0]         idx;
  logic [MAX_TASKS-1:0]     valid;
  logic [OCC_W-1:0]         occ;
  logic [STAMP_W-1:0]       arrival;
  logic signed [PRIO_W-1:0] aging_floor;
  logic [ID_BITS-1:0]       task_q;
  logic signed [PRIO_W-1:0] prio_q;

  logic                     p_act;
  logic                     p_live;
  logic [IDX_W-1:0]         p_idx;

  logic                     have_best;
  logic signed [PRIO_W-1:0] best_dyn;
  logic [STAMP_W-1:0]       best_age;
  logic [IDX_W-1:0]         best_idx;
  logic [ID_BITS-1:0]       best_task;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [WORD_W-1:0]        wdata;
  logic [WORD_W-1:0]        rdata;

  logic [ID_BITS-1:0]       rd_task;
  logic signed [PRIO_W-1:0] rd_dyn;
  logic [STAMP_W-1:0]       rd_stamp;
  logic [STAMP_W-1:0]       rd_age;
  logic signed [PRIO_W-1:0] dyn_aged;
  logic                     take;
  logic                     fin_have;
  logic [IDX_W-1:0]         fin_idx;
  logic [ID_BITS-1:0]       fin_task;

  apts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  assign rd_task  = rdata[WORD_W-1 -: ID_BITS];
  assign rd_dyn   = signed'(rdata[STAMP_W +: PRIO_W]);
  assign rd_stamp = rdata[STAMP_W-1:0];
  assign rd_age   = arrival - rd_stamp;
  assign dyn_aged = (rd_dyn > aging_floor) ? rd_dyn - PRIO_W'(1) : rd_dyn;

  assign take = p_act && p_live &&
                (!have_best || (rd_dyn < best_dyn) ||
                 ((rd_dyn == best_dyn) && (rd_age > best_age)));

  assign fin_have = have_best || take;
  assign fin_idx  = take ? p_idx : best_idx;
  assign fin_task = take ? rd_task : best_task;

  always_comb begin
    we    = 1'b0;
    waddr = p_idx;
    wdata = {rd_task, dyn_aged, rd_stamp};
    if (p_act && p_live) begin
      we = 1'b1;
    end
    if ((state == S_ENQ) && !valid[idx]) begin
      we    = 1'b1;
      waddr = idx;
      wdata = {task_q, prio_q, arrival};
    end
  end

  always_ff @(posedge clk) begin
    p_live <= valid[idx];
    p_idx  <= idx;
    if (take) begin
      best_dyn  <= rd_dyn;
      best_age  <= rd_age;
      best_idx  <= p_idx;
      best_task <= rd_task;
    end
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      valid       <= '0;
      occ         <= '0;
      arrival     <= '0;
      aging_floor <= FLOOR_RESET;
      p_act       <= 1'b0;
      have_best   <= 1'b0;
      done        <= 1'b0;
    end else begin
      done  <= 1'b0;
      p_act <= (state == S_PICK);
      if (take) begin
        have_best <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        aging_floor <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            idx    <= '0;
            task_q <= task_ident;
            prio_q <= priority_req;
            if (!op) begin
              if (occ >= FULL_OCC) begin
                done         <= 1'b1;
                status       <= ST_FULL;
                picked_ident <= '0;
                ready_count  <= COUNT_W'(occ);
              end else begin
                state <= S_ENQ;
              end
            end else begin
              have_best <= 1'b0;
              state     <= S_PICK;
            end
          end
        end
        S_ENQ: begin
          if (!valid[idx]) begin
            valid[idx]   <= 1'b1;
            arrival      <= arrival + 1'b1;
            occ          <= occ + 1'b1;
            done         <= 1'b1;
            status       <= ST_OK;
            picked_ident <= '0;
            ready_count  <= COUNT_W'(OCC_W'(occ + 1'b1));
            state        <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_PICK: begin
          if (idx == LAST_IDX) begin
            state <= S_TAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TAIL: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (fin_have) begin
            valid[fin_idx] <= 1'b0;
            occ            <= occ - 1'b1;
            status         <= ST_OK;
            picked_ident   <= fin_task;
            ready_count    <= COUNT_W'(OCC_W'(occ - 1'b1));
          end else begin
            status       <= ST_EMPTY;
            picked_ident <= '0;
            ready_count  <= COUNT_W'(occ);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/apts_checker.sv */
`default_nettype none

`include "aging_priority_task_selector_defines.svh"

module apts_checker import apts_pkg::*; #(
  parameter int ID_BITS = DEF_ID_BITS
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [STATUS_W-1:0]      status,
  input logic [ID_BITS-1:0]       picked_ident,
  input logic [COUNT_W-1:0]       ready_count
);

  `APTS_ASSERT(a_fail_no_ident, done && (status != ST_OK) |-> picked_ident == '0, "failed beat returns an id")
  `APTS_ASSERT(a_empty_count, done && (status == ST_EMPTY) |-> ready_count == '0, "empty pick with nonzero count")
  `APTS_ASSERT(a_start_reacts, start && !busy |=> busy || done, "accepted beat neither busy nor done")
  `APTS_ASSERT_ALWAYS(a_reset_quiet, !rst && $past(rst) |-> !done, "result strobe right after reset")

endmodule

bind aging_priority_task_selector apts_checker #(.ID_BITS(ID_BITS)) u_apts_checker (.*);

`default_nettype wire
